// ===== rtl/fir_filter_direct_form_macros.svh =====
// Assertion macros used by the FIR filter top level.
`ifndef FIR_FILTER_DIRECT_FORM_MACROS_SVH
`define FIR_FILTER_DIRECT_FORM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FIR_DF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define FIR_DF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fir_df_pkg.sv =====
// Package: constants, types and state encoding for the direct-form FIR filter.
package fir_df_pkg;

    localparam int TAPS     = 32;
    localparam int TAP_AW   = $clog2(TAPS);
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 5;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = PROD_W + TAP_AW;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } fir_state_t;

    typedef struct packed {
        logic clear;  // start of a new sum
        logic vld;    // operands valid this cycle
    } mac_ctl_t;

endpackage

// ===== rtl/fir_filter_direct_form.sv =====
// Top level: direct-form FIR filter with delay line and coefficients held in RAM.
// A sample request (tuser 0) writes the sample into a circular delay-line RAM and then
// walks all TAPS entries, one multiply-accumulate per cycle against the coefficient RAM,
// through the RAM read registers and the product register into the accumulator; a new
// request is taken only once the result is loaded and the block is back in idle. That
// loop over the single read port of each RAM sets the rate. A result that is not yet taken
// holds the block in its last step until the output register frees up. A coefficient
// request (tuser 1) produces no result; indexes at or above TAPS are dropped. Both RAMs
// read as zero until an entry is written, through per-entry valid bits cleared at reset,
// so no clearing pass is needed. Results wait in an output register, and a new request
// is taken while a result is still pending.
module fir_filter_direct_form (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] sample_in, [20:16] coef_index, [36:21] coef_value, [39:37] zero
    input  logic [fir_df_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] filtered_out
    output logic [fir_df_pkg::M_DATA_W-1:0]     m_tdata,
    // [0] saturated
    output logic                                m_tuser
);
    import fir_df_pkg::*;

    `include "fir_filter_direct_form_macros.svh"

    logic signed [SAMPLE_W-1:0] dly_mem  [TAPS];
    logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
    logic [TAPS-1:0]            dly_vld_reg;
    logic [TAPS-1:0]            coef_vld_reg;

    fir_state_t                 state_reg, state_next;
    logic [TAP_AW-1:0]          head_reg;
    logic [TAP_AW-1:0]          head_inc;
    logic [TAP_AW-1:0]          rd_ptr_reg;
    logic [TAP_AW-1:0]          cnt_reg;
    logic                       rd_vld_reg;
    logic                       dq_vld_reg;
    logic                       cq_vld_reg;
    logic signed [SAMPLE_W-1:0] dq_reg;
    logic signed [SAMPLE_W-1:0] cq_reg;
    logic signed [SAMPLE_W-1:0] dly_op;
    logic signed [SAMPLE_W-1:0] coef_op;

    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg;
    logic                       m_tuser_reg;

    logic                       in_req;
    logic                       sample_req;
    logic                       coef_req;
    logic                       coef_ok;
    logic [TAP_AW-1:0]          coef_addr;
    logic                       issue;
    logic                       out_free;
    logic                       out_load;
    mac_ctl_t                   mac_ctl;
    logic                       mac_busy;
    logic signed [SAMPLE_W-1:0] mac_y;
    logic                       mac_sat;

    logic signed [SAMPLE_W-1:0] sample_in;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;

    assign sample_in  = s_tdata[15:0];
    assign coef_index = s_tdata[20:16];
    assign coef_value = s_tdata[36:21];

    assign in_req     = s_tvalid && s_tready;
    assign sample_req = in_req && (s_tuser == KIND_SAMPLE);
    assign coef_req   = in_req && (s_tuser == KIND_COEF);
    assign coef_ok    = 32'(coef_index) < TAPS;
    assign coef_addr  = TAP_AW'(coef_index);
    assign head_inc   = (head_reg == TAP_AW'(TAPS - 1)) ? '0 : head_reg + 1'b1;
    assign issue      = (state_reg == ST_RUN);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == KIND_SAMPLE))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == TAP_AW'(TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last product to land in the accumulator
                if (!rd_vld_reg && !mac_busy && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            dly_vld_reg  <= '0;
            coef_vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (sample_req)
            begin
                head_reg              <= head_inc;
                rd_ptr_reg            <= head_inc;
                cnt_reg               <= '0;
                dly_vld_reg[head_inc] <= 1'b1;
            end
            else if (issue)
            begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? TAP_AW'(TAPS - 1) : rd_ptr_reg - 1'b1;
                cnt_reg    <= cnt_reg + 1'b1;
            end
            if (coef_req && coef_ok)
            begin
                coef_vld_reg[coef_addr] <= 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // delay-line and coefficient RAMs, registered reads
    always_ff @(posedge clk)
    begin
        if (sample_req)
        begin
            dly_mem[head_inc] <= sample_in;
        end
        if (coef_req && coef_ok)
        begin
            coef_mem[coef_addr] <= coef_value;
        end
        dq_reg     <= dly_mem[rd_ptr_reg];
        cq_reg     <= coef_mem[cnt_reg];
        dq_vld_reg <= dly_vld_reg[rd_ptr_reg];
        cq_vld_reg <= coef_vld_reg[cnt_reg];
        if (out_load)
        begin
            m_tdata_reg <= M_DATA_W'(mac_y);
            m_tuser_reg <= mac_sat;
        end
    end

    assign dly_op        = dq_vld_reg ? dq_reg : '0;
    assign coef_op       = cq_vld_reg ? cq_reg : '0;
    assign mac_ctl.clear = sample_req;
    assign mac_ctl.vld   = rd_vld_reg;

    fir_df_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .dly   (dly_op),
        .coef  (coef_op),
        .busy  (mac_busy),
        .y     (mac_y),
        .sat   (mac_sat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FIR_DF_ASSERT_NEXT(a_sample_starts_walk, sample_req, (state_reg == ST_RUN) && (cnt_reg == '0), "sample request did not start the tap walk")
    `FIR_DF_ASSERT_NOW(a_idle_pipe_empty, state_reg == ST_IDLE, !rd_vld_reg && !mac_busy, "MAC pipeline busy while idle")
    `FIR_DF_ASSERT_NOW(a_load_free_slot, out_load, !m_tvalid_reg || m_tready, "result overwrote a pending result")

endmodule

// ===== rtl/fir_df_mac.sv =====
// Multiply-accumulate datapath with round-half-up and Q1.15 saturation.
module fir_df_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fir_df_pkg::mac_ctl_t                  ctl,
    input  logic signed [fir_df_pkg::SAMPLE_W-1:0] dly,
    input  logic signed [fir_df_pkg::SAMPLE_W-1:0] coef,
    output logic                                  busy,
    output logic signed [fir_df_pkg::SAMPLE_W-1:0] y,
    output logic                                  sat
);
    import fir_df_pkg::*;

    localparam int SUM_W = ACC_W + 1;
    localparam int Y_W   = SUM_W - (SAMPLE_W - 1);
    localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32767);
    localparam logic signed [Y_W-1:0] Y_MIN = Y_W'(-32768);
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(16384);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  sum_rnd;
    logic signed [Y_W-1:0]    y_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= dly * coef;
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor((acc + 2^14) / 2^15)
    assign sum_rnd = SUM_W'(acc_reg) + HALF;
    assign y_full  = Y_W'(sum_rnd >>> (SAMPLE_W - 1));
    assign busy    = prod_vld_reg;

    always_comb
    begin
        priority if (y_full > Y_MAX)
        begin
            y   = 16'sh7FFF;
            sat = 1'b1;
        end
        else if (y_full < Y_MIN)
        begin
            y   = -16'sh8000;
            sat = 1'b1;
        end
        else
        begin
            y   = SAMPLE_W'(y_full);
            sat = 1'b0;
        end
    end

endmodule
